FILE: src/cpef_pkg.sv
package cpef_pkg;

  // Field widths
  localparam int unsigned ENERGY_W = 24;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned ID_W     = 32;

  // Layer codes
  localparam logic [1:0] LAYER_OTHER   = 2'd0;
  localparam logic [1:0] LAYER_SCATTER = 2'd1;
  localparam logic [1:0] LAYER_ABSORB  = 2'd2;
  localparam logic [1:0] LAYER_UNUSED  = 2'd3;  // treated as other

  // Item modes
  localparam logic MODE_HIT   = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Register map (word index taken from paddr[2])
  localparam logic REG_REST_ENERGY = 1'b0;
  localparam logic [ENERGY_W-1:0] REST_ENERGY_RESET = 24'd511000;

  // One detector hit or flush beat
  typedef struct packed {
    logic                    mode;
    logic [ID_W-1:0]         event_id;
    logic [ENERGY_W-1:0]     hit_energy;
    logic signed [POS_W-1:0] hit_x;
    logic signed [POS_W-1:0] hit_y;
    logic signed [POS_W-1:0] hit_z;
    logic [1:0]              layer;
  } hit_t;

  // One coincidence pair
  typedef struct packed {
    logic [ENERGY_W-1:0]     scatter_energy;
    logic signed [POS_W-1:0] scatter_x;
    logic signed [POS_W-1:0] scatter_y;
    logic signed [POS_W-1:0] scatter_z;
    logic [ENERGY_W-1:0]     absorb_energy;
    logic signed [POS_W-1:0] absorb_x;
    logic signed [POS_W-1:0] absorb_y;
    logic signed [POS_W-1:0] absorb_z;
  } pair_t;

  // A held hit of the open group
  typedef struct packed {
    logic [ENERGY_W-1:0]     energy;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic [1:0]              layer;
  } held_t;

endpackage

FILE: src/cpef_fifo.sv
module cpef_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: src/cpef_front.sv
module cpef_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hit_valid,
  input  cpef_pkg::hit_t hit,
  output logic           cand_push,
  output cpef_pkg::pair_t cand
);

  logic                      group_active_r;
  logic [cpef_pkg::ID_W-1:0] group_id_r;
  logic [1:0]                group_count_r;
  cpef_pkg::held_t           held_r [2];
  cpef_pkg::held_t           hit_held;
  logic                      same_group;
  logic                      closing;
  logic                      pair_ok;

  // Classify the beat against the open group
  always_comb begin
    hit_held.energy = hit.hit_energy;
    hit_held.x      = hit.hit_x;
    hit_held.y      = hit.hit_y;
    hit_held.z      = hit.hit_z;
    hit_held.layer  = hit.layer;
    same_group = group_active_r && (hit.event_id == group_id_r);
    closing    = hit_valid && ((hit.mode == cpef_pkg::MODE_FLUSH) || !same_group);
    pair_ok    = group_active_r && (group_count_r == 2'd2) &&
                 (held_r[0].layer == cpef_pkg::LAYER_SCATTER) &&
                 (held_r[1].layer == cpef_pkg::LAYER_ABSORB);
  end

  // Candidate pair toward the energy check
  assign cand_push = closing && pair_ok;
  always_comb begin
    cand.scatter_energy = held_r[0].energy;
    cand.scatter_x      = held_r[0].x;
    cand.scatter_y      = held_r[0].y;
    cand.scatter_z      = held_r[0].z;
    cand.absorb_energy  = held_r[1].energy;
    cand.absorb_x       = held_r[1].x;
    cand.absorb_y       = held_r[1].y;
    cand.absorb_z       = held_r[1].z;
  end

  // Group tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_active_r <= 1'b0;
      group_id_r     <= '0;
      group_count_r  <= '0;
    end else if (hit_valid) begin
      if (hit.mode == cpef_pkg::MODE_FLUSH) begin
        group_active_r <= 1'b0;
        group_count_r  <= '0;
      end else if (same_group) begin
        if (group_count_r != 2'd3) begin
          group_count_r <= group_count_r + 1'b1;
        end
      end else begin
        group_active_r <= 1'b1;
        group_id_r     <= hit.event_id;
        group_count_r  <= 2'd1;
      end
    end
  end

  // Held hits, first two of the group
  always_ff @(posedge clk) begin
    if (hit_valid && hit.mode == cpef_pkg::MODE_HIT) begin
      if (!same_group) begin
        held_r[0] <= hit_held;
      end else if (group_count_r < 2'd2) begin
        held_r[group_count_r[0]] <= hit_held;
      end
    end
  end

endmodule

FILE: src/cpef_back.sv
module cpef_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [cpef_pkg::ENERGY_W-1:0]      rest_energy,
  input  logic                               cand_valid,
  input  cpef_pkg::pair_t                    cand,
  output logic                               cand_pop,
  output logic                               res_push,
  output cpef_pkg::pair_t                    res,
  input  logic                               res_full
);

  localparam int unsigned LHS_W = 2 * cpef_pkg::ENERGY_W;
  localparam int unsigned RHS_W = 2 * cpef_pkg::ENERGY_W + 1;

  logic             s1_v_r, s1_v_nxt;
  logic [LHS_W-1:0] s1_lhs_r, lhs_nxt;
  logic [RHS_W-1:0] s1_rhs_r, rhs_nxt;
  cpef_pkg::pair_t  s1_pair_r;
  logic             keep;
  logic             s1_go;
  logic             s1_rdy;

  // Products: rest*E1 and E2*(E1+E2)
  always_comb begin
    lhs_nxt = LHS_W'(rest_energy) * LHS_W'(cand.scatter_energy);
    rhs_nxt = RHS_W'(cand.absorb_energy) *
              (RHS_W'(cand.scatter_energy) + RHS_W'(cand.absorb_energy));
  end

  // Cosine within range: E2 > 0 and rest*E1 <= 2*E2*(E1+E2)
  assign keep   = (s1_pair_r.absorb_energy != '0) &&
                  ({2'b00, s1_lhs_r} <= {s1_rhs_r, 1'b0});
  assign s1_go  = s1_v_r && (!keep || !res_full);
  assign s1_rdy = !s1_v_r || s1_go;

  assign cand_pop = cand_valid && s1_rdy;
  assign res_push = s1_v_r && keep && !res_full;
  assign res      = s1_pair_r;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (cand_pop) begin
      s1_v_nxt = 1'b1;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (cand_pop) begin
      s1_lhs_r  <= lhs_nxt;
      s1_rhs_r  <= rhs_nxt;
      s1_pair_r <= cand;
    end
  end

endmodule

FILE: src/compton_pair_event_filter_unit.sv
// Compton pair event filter: groups hits by event id and emits scatter/absorb pairs.
// Throughput: one beat per cycle; push is refused only while the pair queue is full.
// Path: the beat that closes a group writes its pair into the pair queue; the pair then moves
// into the product register and, once compared, into the result queue.
// Reset (rst_n low, synchronous): queues empty, no open group, rest_energy = 511000.
module compton_pair_event_filter_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input side
  input  logic                          push,
  output logic                          full,
  input  cpef_pkg::hit_t                in_data,
  // result queue side
  output logic                          empty,
  input  logic                          pop,
  output cpef_pkg::pair_t               out_data,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [cpef_pkg::ENERGY_W-1:0] rest_energy_r;
  logic                          cfg_wr;
  logic                          in_beat;
  logic                          cand_push, cand_full, cand_pop, cand_empty;
  cpef_pkg::pair_t               cand_wdata, cand_rdata;
  logic                          res_push, res_full;
  cpef_pkg::pair_t               res_wdata;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == cpef_pkg::REG_REST_ENERGY) ?
                  {8'h00, rest_energy_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_energy_r <= cpef_pkg::REST_ENERGY_RESET;
    end else if (cfg_wr && paddr[2] == cpef_pkg::REG_REST_ENERGY) begin
      rest_energy_r <= pwdata[cpef_pkg::ENERGY_W-1:0];
    end
  end

  // Front: grouping and pair selection
  assign full    = cand_full;
  assign in_beat = push && !full;

  cpef_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit_valid (in_beat),
    .hit       (in_data),
    .cand_push (cand_push),
    .cand      (cand_wdata)
  );

  // Queue between front and energy check
  cpef_fifo #(.T(cpef_pkg::pair_t), .DEPTH(QUEUE_DEPTH)) u_cand_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cand_push),
    .wdata (cand_wdata),
    .full  (cand_full),
    .pop   (cand_pop),
    .rdata (cand_rdata),
    .empty (cand_empty)
  );

  // Back: Compton cosine check
  cpef_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .rest_energy (rest_energy_r),
    .cand_valid  (!cand_empty),
    .cand        (cand_rdata),
    .cand_pop    (cand_pop),
    .res_push    (res_push),
    .res         (res_wdata),
    .res_full    (res_full)
  );

  // Result queue
  cpef_fifo #(.T(cpef_pkg::pair_t), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

FILE: src/cpef_checker.sv
module cpef_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            empty,
  input logic            pop,
  input cpef_pkg::pair_t out_data,
  input logic            psel,
  input logic            penable,
  input logic            pwrite,
  input logic [2:0]      paddr,
  input logic [31:0]     pwdata,
  input logic [31:0]     prdata,
  input logic            pready
);

  // Reset leaves the result queue empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Register readback carries only the 24 bit field
  a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
    prdata[31:24] == 8'h00)
    else $error("upper readback bits not zero");

  // A completed write is visible on readback in the next cycle
  a_write_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && !paddr[2]) |=>
      (paddr[2] || prdata[23:0] == $past(pwdata[23:0])))
    else $error("rest_energy readback mismatch");

  // A waiting result stays put until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or dropped");

endmodule

bind compton_pair_event_filter_unit cpef_checker u_cpef_checker (.*);
